@@ hw/rtl/i2cms_pkg.sv @@
// Shared types for the I2C master transfer sequencer: event codes, action and
// status codes, and the request and response transfer payloads.
// No dependencies.
package i2cms_pkg;

   localparam int COUNT_WIDTH_DEF = 16;
   localparam logic [7:0] TEN_BIT_TAG = 8'hf0;

   typedef enum logic [1:0] {
      OP_BEGIN        = 2'd0,
      OP_BYTE_DONE    = 2'd1,
      OP_STOP_DONE    = 2'd2,
      OP_WAIT_TIMEOUT = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_START   = 3'd1,
      ACT_RSTART  = 3'd2,
      ACT_SEND    = 3'd3,
      ACT_RX_ACK  = 3'd4,
      ACT_RX_NACK = 3'd5,
      ACT_STOP    = 3'd6,
      ACT_DROP    = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      ST_BUSY      = 3'd0,
      ST_DONE      = 3'd1,
      ST_INVALID   = 3'd2,
      ST_ARB       = 3'd3,
      ST_TIMEOUT   = 3'd4,
      ST_ADDR_NACK = 3'd5,
      ST_DATA_NACK = 3'd6,
      ST_BUS_BUSY  = 3'd7
   } status_type;

   typedef struct packed {
      op_type      operation;
      logic [9:0]  target_address;
      logic        read_not_write;
      logic        ten_bit;
      logic        skip_start;
      logic        skip_stop;
      logic [15:0] byte_count;
      logic        arbitration_lost;
      logic        bus_busy;
      logic        acknowledge_missing;
      logic [7:0]  data_byte;
      logic        stop_timed_out;
   } i2cms_req_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  out_byte;
      logic        read_valid;
      logic [7:0]  read_byte;
      status_type  status;
      logic        last;
   } i2cms_rsp_type;

endpackage

@@ hw/rtl/i2cms_req_if.sv @@
// Valid/ready channel that carries bus events into the sequencer.
// Depends on i2cms_pkg for the payload type.
interface i2cms_req_if;
   logic                     valid;
   logic                     ready;
   i2cms_pkg::i2cms_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/i2cms_rsp_if.sv @@
// Valid/ready channel that carries bus commands and status out of the sequencer.
// Depends on i2cms_pkg for the payload type.
interface i2cms_rsp_if;
   logic                     valid;
   logic                     ready;
   i2cms_pkg::i2cms_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/i2c_master_transfer_sequencer.sv @@
// I2C master transfer sequencer: top level with the event decoder and the
// response queue. Depends on i2cms_pkg, i2cms_req_if and i2cms_rsp_if.
//
// Usage: bus events (begin, byte complete, stop complete, wait timeout) come in
// on req_bus; for each event the block issues one or two responses on rsp_bus,
// each carrying a bus command, an optional received byte and a status. The
// last response of an event has last set. A begin that issues a fresh start gives
// two responses (start or repeated start, then the address byte or a drop).
// Path: an accepted event is held in the input register, then decoded into
// a four-entry response queue whose head drives rsp_bus when it is not empty.
// Throughput: one single-response event per cycle while the receiver takes one
// response per cycle; the rate is set by the response queue, which drains one
// response a cycle, so a two-response event holds the output for both transfers.
// Reset: synchronous, active high; the phase returns to idle, the bus is
// not held, the byte count is zero, stop is wanted and the queue is empty.
// Stall: when rsp_bus.ready is low the head response holds; the queue keeps
// taking decoded events until it cannot hold two more, then req_bus.ready
// falls once the input register is also full. Nothing is dropped.
module i2c_master_transfer_sequencer #(
   parameter int COUNT_WIDTH = i2cms_pkg::COUNT_WIDTH_DEF
) (
   input logic          clock,
   input logic          reset,
   i2cms_req_if.sink    req_bus,
   i2cms_rsp_if.source  rsp_bus
);
   import i2cms_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_TAG   = 3'd1,
      PH_ADDR  = 3'd2,
      PH_WRITE = 3'd3,
      PH_READ  = 3'd4,
      PH_STOP  = 3'd5
   } phase_type;

   typedef struct packed {
      phase_type     phase;
      i2cms_rsp_type res;
   } step_type;

   localparam int DEPTH     = 4;
   localparam int PTR_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);

   function automatic i2cms_rsp_type mk_res(action_type act, logic [7:0] byte_val,
                                            status_type st);
      i2cms_rsp_type r;
      r.action     = act;
      r.out_byte   = byte_val;
      r.read_valid = 1'b0;
      r.read_byte  = 8'd0;
      r.status     = st;
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic step_type finish_step(logic stopw);
      step_type s;
      if (stopw) begin
         s.phase = PH_STOP;
         s.res   = mk_res(ACT_STOP, 8'd0, ST_BUSY);
      end else begin
         s.phase = PH_IDLE;
         s.res   = mk_res(ACT_NONE, 8'd0, ST_DONE);
      end
      return s;
   endfunction

   function automatic step_type data_step(logic [COUNT_WIDTH-1:0] cnt, logic rd,
                                          logic stopw, logic [7:0] data);
      step_type s;
      if (cnt == '0) begin
         s = finish_step(stopw);
      end else if (rd) begin
         s.phase = PH_READ;
         s.res   = mk_res((cnt == COUNT_WIDTH'(1)) ? ACT_RX_NACK : ACT_RX_ACK,
                          8'd0, ST_BUSY);
      end else begin
         s.phase = PH_WRITE;
         s.res   = mk_res(ACT_SEND, data, ST_BUSY);
      end
      return s;
   endfunction

   // Input register.
   logic          s1_valid_ff, s1_valid_in;
   i2cms_req_type s1_item_ff;

   // Transfer state.
   phase_type              phase_ff, phase_in;
   logic                   held_ff, held_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic                   reading_ff, reading_in;
   logic                   stopw_ff, stopw_in;
   logic [7:0]             low_ff, low_in;

   // Response queue.
   i2cms_rsp_type     fifo_ff [DEPTH];
   logic [PTR_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   i2cms_rsp_type          r0, r1;
   logic                   two;
   step_type               stp;
   logic [COUNT_WIDTH-1:0] cnt_new, rem_dec;
   logic                   adv, pop, req_take;

   assign pop      = rsp_bus.valid && rsp_bus.ready;
   assign adv      = s1_valid_ff &&
                     ((count_ff <= CNT_W'(DEPTH - 2)) ||
                      (pop && count_ff == CNT_W'(DEPTH - 1)));
   assign req_bus.ready = !s1_valid_ff || adv;
   assign req_take = req_bus.valid && req_bus.ready;
   assign s1_valid_in = req_take || (s1_valid_ff && !adv);

   assign rsp_bus.valid   = (count_ff != '0);
   assign rsp_bus.payload = fifo_ff[head_ff];

   assign cnt_new = COUNT_WIDTH'(s1_item_ff.byte_count);
   assign rem_dec = rem_ff - COUNT_WIDTH'(1);

   // Event decoder: one item against the transfer state.
   always_comb begin
      r0         = mk_res(ACT_NONE, 8'd0, ST_INVALID);
      r1         = mk_res(ACT_NONE, 8'd0, ST_BUSY);
      two        = 1'b0;
      stp        = '0;
      phase_in   = phase_ff;
      held_in    = held_ff;
      rem_in     = rem_ff;
      reading_in = reading_ff;
      stopw_in   = stopw_ff;
      low_in     = low_ff;
      case (s1_item_ff.operation)
         OP_BEGIN: begin
            if (phase_ff != PH_IDLE) begin
               // A begin during a running transfer is rejected.
            end else if (s1_item_ff.skip_start) begin
               if (held_ff) begin
                  reading_in = s1_item_ff.read_not_write;
                  stopw_in   = !s1_item_ff.skip_stop;
                  rem_in     = cnt_new;
                  stp        = data_step(cnt_new, s1_item_ff.read_not_write,
                                         !s1_item_ff.skip_stop, s1_item_ff.data_byte);
                  phase_in   = stp.phase;
                  r0         = stp.res;
               end
            end else if (!held_ff && s1_item_ff.read_not_write && s1_item_ff.ten_bit) begin
               // A 10-bit read needs the bus already held for the tag phase.
            end else if (!held_ff && s1_item_ff.bus_busy) begin
               r0 = mk_res(ACT_NONE, 8'd0, ST_BUS_BUSY);
            end else begin
               reading_in = s1_item_ff.read_not_write;
               stopw_in   = !s1_item_ff.skip_stop;
               rem_in     = cnt_new;
               low_in     = s1_item_ff.target_address[7:0];
               r0         = mk_res(held_ff ? ACT_RSTART : ACT_START, 8'd0, ST_BUSY);
               held_in    = 1'b1;
               two        = 1'b1;
               if (s1_item_ff.arbitration_lost) begin
                  held_in  = 1'b0;
                  phase_in = PH_IDLE;
                  r1       = mk_res(ACT_DROP, 8'd0, ST_ARB);
               end else if (s1_item_ff.ten_bit) begin
                  r1 = mk_res(ACT_SEND, TEN_BIT_TAG |
                              {5'd0, s1_item_ff.target_address[9:8],
                               s1_item_ff.read_not_write}, ST_BUSY);
                  phase_in = s1_item_ff.read_not_write ? PH_ADDR : PH_TAG;
               end else begin
                  r1 = mk_res(ACT_SEND, {s1_item_ff.target_address[6:0],
                                         s1_item_ff.read_not_write}, ST_BUSY);
                  phase_in = PH_ADDR;
               end
            end
         end
         OP_BYTE_DONE: begin
            unique case (phase_ff)
               PH_TAG, PH_ADDR: begin
                  if (s1_item_ff.arbitration_lost) begin
                     held_in  = 1'b0;
                     phase_in = PH_IDLE;
                     r0       = mk_res(ACT_DROP, 8'd0, ST_ARB);
                  end else if (s1_item_ff.acknowledge_missing) begin
                     held_in  = 1'b0;
                     phase_in = PH_IDLE;
                     r0       = mk_res(ACT_DROP, 8'd0, ST_ADDR_NACK);
                  end else if (phase_ff == PH_TAG) begin
                     phase_in = PH_ADDR;
                     r0       = mk_res(ACT_SEND, low_ff, ST_BUSY);
                  end else begin
                     stp      = data_step(rem_ff, reading_ff, stopw_ff,
                                          s1_item_ff.data_byte);
                     phase_in = stp.phase;
                     r0       = stp.res;
                  end
               end
               PH_WRITE: begin
                  if (s1_item_ff.arbitration_lost) begin
                     held_in  = 1'b0;
                     phase_in = PH_IDLE;
                     r0       = mk_res(ACT_DROP, 8'd0, ST_ARB);
                  end else begin
                     rem_in = rem_dec;
                     // A NACK on the final written byte is accepted.
                     if (rem_dec == '0) begin
                        stp      = finish_step(stopw_ff);
                        phase_in = stp.phase;
                        r0       = stp.res;
                     end else if (s1_item_ff.acknowledge_missing) begin
                        held_in  = 1'b0;
                        phase_in = PH_IDLE;
                        r0       = mk_res(ACT_DROP, 8'd0, ST_DATA_NACK);
                     end else begin
                        r0 = mk_res(ACT_SEND, s1_item_ff.data_byte, ST_BUSY);
                     end
                  end
               end
               PH_READ: begin
                  if (s1_item_ff.arbitration_lost) begin
                     held_in  = 1'b0;
                     phase_in = PH_IDLE;
                     r0       = mk_res(ACT_DROP, 8'd0, ST_ARB);
                  end else begin
                     rem_in = rem_dec;
                     if (rem_dec == '0) begin
                        stp      = finish_step(stopw_ff);
                        phase_in = stp.phase;
                        r0       = stp.res;
                     end else begin
                        r0 = mk_res((rem_dec == COUNT_WIDTH'(1)) ? ACT_RX_NACK
                                                                 : ACT_RX_ACK,
                                    8'd0, ST_BUSY);
                     end
                     r0.read_valid = 1'b1;
                     r0.read_byte  = s1_item_ff.data_byte;
                  end
               end
               default: begin
               end
            endcase
         end
         OP_STOP_DONE: begin
            if (phase_ff == PH_STOP) begin
               held_in  = 1'b0;
               phase_in = PH_IDLE;
               r0       = mk_res(ACT_NONE, 8'd0,
                                 s1_item_ff.stop_timed_out ? ST_TIMEOUT : ST_DONE);
            end
         end
         default: begin
            if (phase_ff == PH_STOP) begin
               held_in  = 1'b0;
               phase_in = PH_IDLE;
               r0       = mk_res(ACT_NONE, 8'd0, ST_TIMEOUT);
            end else if (phase_ff != PH_IDLE) begin
               held_in  = 1'b0;
               phase_in = PH_IDLE;
               r0       = mk_res(ACT_DROP, 8'd0, ST_TIMEOUT);
            end
         end
      endcase
      r0.last = !two;
      r1.last = 1'b1;
   end

   always_comb begin
      head_in  = pop ? head_ff + PTR_W'(1) : head_ff;
      tail_in  = tail_ff;
      count_in = count_ff - CNT_W'(pop);
      if (adv) begin
         tail_in  = tail_ff + (two ? PTR_W'(2) : PTR_W'(1));
         count_in = count_in + (two ? CNT_W'(2) : CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_bus.payload;
      end
      if (adv) begin
         fifo_ff[tail_ff] <= r0;
         if (two) begin
            fifo_ff[tail_ff + PTR_W'(1)] <= r1;
         end
         rem_ff <= rem_in;
         low_ff <= low_in;
      end
      if (reset) begin
         s1_valid_ff <= 1'b0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         phase_ff    <= PH_IDLE;
         held_ff     <= 1'b0;
         reading_ff  <= 1'b0;
         stopw_ff    <= 1'b1;
         rem_ff      <= '0;
         low_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         if (adv) begin
            phase_ff   <= phase_in;
            held_ff    <= held_in;
            reading_ff <= reading_in;
            stopw_ff   <= stopw_in;
         end
      end
   end

   // The queue never holds more responses than it has entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("response queue overflow");

   // Every phase other than idle belongs to a transfer that holds the bus.
   a_phase_held: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> held_ff)
      else $error("active phase without bus mastership");

   // A decoded item is only moved on when the queue has room for both responses.
   a_room: assert property (@(posedge clock) disable iff (reset)
      adv |=> count_ff <= CNT_W'(DEPTH))
      else $error("decoded item moved without queue room");

   // The queue starts empty when reset is released.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> count_ff == '0 && !rsp_bus.valid)
      else $error("queue not empty after reset");

endmodule
